// ===== src/nvmq_pkg.sv =====
// Shared types, codes and constants for the NVMe I/O queue pair host block.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package nvmq_pkg;

  // Queue sizing; pointers are as wide as the depth needs.
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int DB_W        = 3;
  localparam int DB_EXT_W    = PTR_W + DB_W;

  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 248;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [4:0]  PAGE_PAIR_SECTORS = 5'd16;
  localparam logic [15:0] ONE_PAGE_SECTORS  = 16'd8;
  localparam logic [63:0] PAGE_BYTES        = 64'd4096;
  localparam logic [31:0] WAIT_SATURATED    = 32'hFFFF_FFFF;
  localparam logic [31:0] TIMEOUT_RESET     = 32'd200000000;

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_TICK     = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_ISSUED    = 3'd0,
    EV_REJECTED  = 3'd1,
    EV_DONE_OK   = 3'd2,
    EV_DONE_ERR  = 3'd3,
    EV_TIMED_OUT = 3'd4
  } event_t;

  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IO_ENABLED   = 3'd0,
    REG_CAPACITY     = 3'd1,
    REG_SECTOR_LIMIT = 3'd2,
    REG_BOUNCE_BASE  = 3'd3,
    REG_TIMEOUT      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        io_enabled;
    logic [63:0] capacity_sectors;
    logic [4:0]  sector_limit;
    logic [63:0] bounce_base;
    logic [31:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] lba;
    logic [15:0] count;
    logic        is_write;
    logic [15:0] cqe_status;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [1:0]  sqe_opcode;
    logic [15:0] command_id;
    logic [63:0] prp_first;
    logic [63:0] prp_second;
    logic [63:0] start_block;
    logic [15:0] block_count_minus_one;
    logic [2:0]  sq_doorbell_value;
    logic [2:0]  cq_doorbell_value;
    logic [14:0] status_field;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

  // Doorbell fields report the pointer modulo eight.
  function automatic logic [DB_W-1:0] doorbell(input logic [PTR_W-1:0] ptr);
    logic [DB_EXT_W-1:0] ext;
    ext = DB_EXT_W'(ptr);
    return ext[DB_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/nvme_io_queue_pair_host.sv =====
// Host side of one NVMe I/O queue pair with one command in flight.
// A result is registered: the input register loads at the transfer edge and
// the result register loads when the decision logic retires the item.
// Throughput: one item per cycle while the result register can take each
// result; the input register refills in the same cycle the decision logic
// retires. Reset (rst, synchronous, active high) clears pointers, command
// id, busy and wait counter, sets the expected phase and restores config.
`timescale 1ns / 1ps
`default_nettype none

module nvme_io_queue_pair_host
  import nvmq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // lba[63:0], count[79:64], is_write[80], cqe_status[96:81], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // sqe_opcode[1:0], command_id[17:2], prp_first[81:18], prp_second[145:82],
  // start_block[209:146], block_count_minus_one[225:210],
  // sq_doorbell_value[228:226], cq_doorbell_value[231:229],
  // status_field[246:232], zero fill
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // event_res[2:0]
  output logic [2:0]                 m_tuser
);

  cfg_t    cfg;
  item_t   in_item, item;
  logic    item_valid, advance, has_result, can_load, in_load;
  result_t result, res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.io_enabled       <= 1'b0;
      cfg.capacity_sectors <= '0;
      cfg.sector_limit     <= PAGE_PAIR_SECTORS;
      cfg.bounce_base      <= '0;
      cfg.timeout_ticks    <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_IO_ENABLED:   cfg.io_enabled       <= cfg_data[0];
        REG_CAPACITY:     cfg.capacity_sectors <= cfg_data;
        REG_SECTOR_LIMIT: cfg.sector_limit     <= cfg_data[4:0];
        REG_BOUNCE_BASE:  cfg.bounce_base      <= cfg_data;
        REG_TIMEOUT:      cfg.timeout_ticks    <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.opcode     = s_tuser;
    in_item.lba        = s_tdata[63:0];
    in_item.count      = s_tdata[79:64];
    in_item.is_write   = s_tdata[80];
    in_item.cqe_status = s_tdata[96:81];
  end

  // An item retires when it produces no result or the result register frees up.
  assign advance  = item_valid && (!has_result || can_load);
  assign s_tready = !item_valid || advance;
  assign in_load  = s_tvalid && s_tready;

  nvmq_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .load      (in_load),
    .load_item (in_item),
    .advance   (advance),
    .item_valid(item_valid),
    .item      (item)
  );

  nvmq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .item_valid(item_valid),
    .advance   (advance),
    .has_result(has_result),
    .result    (result)
  );

  nvmq_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && has_result),
    .load_result(result),
    .taken      (m_tready),
    .can_load   (can_load),
    .res_valid  (m_tvalid),
    .res        (res)
  );

  assign m_tuser = res.event_res;
  assign m_tdata = {1'b0,
                    res.status_field,
                    res.cq_doorbell_value,
                    res.sq_doorbell_value,
                    res.block_count_minus_one,
                    res.start_block,
                    res.prp_second,
                    res.prp_first,
                    res.command_id,
                    res.sqe_opcode};

endmodule

`default_nettype wire

// ===== src/nvmq_in_stage.sv =====
// Input register for the queue pair host: holds one accepted item.
// Depends on nvmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nvmq_in_stage
  import nvmq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  load,
  input  wire item_t load_item,
  input  wire logic  advance,
  output logic       item_valid,
  output item_t      item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
    if (load) begin
      item <= load_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/nvmq_engine.sv =====
// Queue pair state and per-item decision logic: submit checks, completion
// phase tracking and the wait timer. Depends on nvmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nvmq_engine
  import nvmq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire item_t item,
  input  wire logic  item_valid,
  input  wire logic  advance,
  output logic       has_result,
  output result_t    result
);

  logic [PTR_W-1:0] sub_tail, sub_tail_next;
  logic [PTR_W-1:0] comp_head, comp_head_next;
  logic             expected_phase, expected_phase_next;
  logic [15:0]      next_command_id, next_command_id_next;
  logic             busy, busy_next;
  logic [31:0]      wait_count, wait_count_next;

  logic [4:0]  limit;
  logic [63:0] room;
  logic        submit_ok;
  logic [31:0] wait_inc;
  logic [14:0] st;

  always_comb begin
    limit = (cfg.sector_limit < PAGE_PAIR_SECTORS) ? cfg.sector_limit : PAGE_PAIR_SECTORS;
    room  = cfg.capacity_sectors - item.lba;
    submit_ok = cfg.io_enabled && (item.count != 16'd0) && (item.count[15:5] == 11'd0) &&
                (item.count[4:0] <= limit) && (item.lba < cfg.capacity_sectors) &&
                ({48'd0, item.count} <= room) && !busy;
    wait_inc = (wait_count == WAIT_SATURATED) ? wait_count : wait_count + 32'd1;
    st = item.cqe_status[15:1];

    sub_tail_next        = sub_tail;
    comp_head_next       = comp_head;
    expected_phase_next  = expected_phase;
    next_command_id_next = next_command_id;
    busy_next            = busy;
    wait_count_next      = wait_count;
    has_result           = 1'b0;
    result               = '0;

    case (op_t'(item.opcode))
      OP_SUBMIT: begin
        has_result = 1'b1;
        if (submit_ok) begin
          sub_tail_next               = ptr_inc(sub_tail);
          next_command_id_next        = next_command_id + 16'd1;
          busy_next                   = 1'b1;
          wait_count_next             = '0;
          result.event_res            = EV_ISSUED;
          result.sqe_opcode           = item.is_write ? CMD_WRITE : CMD_READ;
          result.command_id           = next_command_id;
          result.prp_first            = cfg.bounce_base;
          // More than one page of 512-byte sectors needs the second pointer.
          result.prp_second           = (item.count > ONE_PAGE_SECTORS) ?
                                        cfg.bounce_base + PAGE_BYTES : 64'd0;
          result.start_block          = item.lba;
          result.block_count_minus_one = item.count - 16'd1;
          result.sq_doorbell_value    = doorbell(sub_tail_next);
        end else begin
          result.event_res = EV_REJECTED;
        end
      end
      OP_COMPLETE: begin
        if (busy && (item.cqe_status[0] == expected_phase)) begin
          has_result     = 1'b1;
          comp_head_next = ptr_inc(comp_head);
          if (comp_head_next == '0) begin
            expected_phase_next = ~expected_phase;
          end
          busy_next                = 1'b0;
          wait_count_next          = '0;
          result.event_res         = (st == 15'd0) ? EV_DONE_OK : EV_DONE_ERR;
          result.command_id        = next_command_id - 16'd1;
          result.cq_doorbell_value = doorbell(comp_head_next);
          result.status_field      = st;
        end
      end
      OP_TICK: begin
        if (busy) begin
          if (wait_inc >= cfg.timeout_ticks) begin
            has_result        = 1'b1;
            busy_next         = 1'b0;
            wait_count_next   = '0;
            result.event_res  = EV_TIMED_OUT;
            result.command_id = next_command_id - 16'd1;
          end else begin
            wait_count_next = wait_inc;
          end
        end
      end
      default: begin
      end
    endcase

    if (!item_valid) begin
      has_result = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_tail        <= '0;
      comp_head       <= '0;
      expected_phase  <= 1'b1;
      next_command_id <= '0;
      busy            <= 1'b0;
      wait_count      <= '0;
    end else if (advance) begin
      sub_tail        <= sub_tail_next;
      comp_head       <= comp_head_next;
      expected_phase  <= expected_phase_next;
      next_command_id <= next_command_id_next;
      busy            <= busy_next;
      wait_count      <= wait_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/nvmq_out_stage.sv =====
// Result register for the queue pair host: holds one result until the
// downstream side takes it. Depends on nvmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nvmq_out_stage
  import nvmq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_result,
  input  wire logic    taken,
  output logic         can_load,
  output logic         res_valid,
  output result_t      res
);

  assign can_load = !res_valid || taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (taken) begin
      res_valid <= 1'b0;
    end
    if (load) begin
      res <= load_result;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/nvmq_queue_pair_checker.sv =====
// Checker for the NVMe I/O queue pair host: watches the config port and both stream
// channels, predicts every result and compares it field by field.
// Depends on nvmq_pkg for the codes, the result layout and the queue depth.
`timescale 1ns / 1ps

module nvmq_queue_pair_checker
  import nvmq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [2:0]            m_tuser,
  output int                    errors,
  output int                    outstanding
);

  // Shadow copy of the configuration registers.
  logic        io_en;
  logic [63:0] cap_sectors;
  logic [4:0]  max_sec;
  logic [63:0] buf_base;
  logic [31:0] tick_limit;

  // Shadow copy of the queue pair state.
  int unsigned sq_tail;
  int unsigned cq_head;
  logic        phase;
  logic [15:0] next_id;
  logic        busy;
  logic [31:0] wait_cnt;

  result_t io_events_q[$];
  int      n_bad  = 0;
  int      n_open = 0;

  assign errors      = n_bad;
  assign outstanding = n_open;

  task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_bad++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      flag(what, got, want);
    end
  endtask

  // Works out the result of one accepted item and advances the shadow state.
  function automatic bit next_io_event(input op_t op, input logic [63:0] lba,
                                       input logic [15:0] cnt, input logic wr,
                                       input logic [15:0] cqe, output result_t r);
    logic [4:0] lim;
    bit         fits;
    r = '0;
    case (op)
      OP_SUBMIT: begin
        // Two page pointers cover 8 KiB, so the limit never exceeds 16 sectors.
        lim  = (max_sec < PAGE_PAIR_SECTORS) ? max_sec : PAGE_PAIR_SECTORS;
        fits = io_en && cnt != 16'd0 && cnt <= 16'(lim) && lba < cap_sectors &&
               64'(cnt) <= cap_sectors - lba && !busy;
        if (!fits) begin
          r.event_res = EV_REJECTED;
          return 1'b1;
        end
        r.event_res  = EV_ISSUED;
        r.sqe_opcode = wr ? CMD_WRITE : CMD_READ;
        r.command_id = next_id;
        next_id      = next_id + 16'd1;
        sq_tail      = (sq_tail + 1) % QUEUE_DEPTH;
        busy         = 1'b1;
        wait_cnt     = '0;
        r.prp_first  = buf_base;
        r.prp_second = (cnt > ONE_PAGE_SECTORS) ? buf_base + PAGE_BYTES : 64'd0;
        r.start_block           = lba;
        r.block_count_minus_one = cnt - 16'd1;
        r.sq_doorbell_value     = 3'(sq_tail);
        return 1'b1;
      end
      OP_COMPLETE: begin
        if (!busy || cqe[0] != phase) begin
          return 1'b0;
        end
        cq_head = (cq_head + 1) % QUEUE_DEPTH;
        if (cq_head == 0) begin
          phase = ~phase;
        end
        busy     = 1'b0;
        wait_cnt = '0;
        r.event_res         = (cqe[15:1] == 15'd0) ? EV_DONE_OK : EV_DONE_ERR;
        r.command_id        = next_id - 16'd1;
        r.cq_doorbell_value = 3'(cq_head);
        r.status_field      = cqe[15:1];
        return 1'b1;
      end
      OP_TICK: begin
        if (!busy) begin
          return 1'b0;
        end
        if (wait_cnt != WAIT_SATURATED) begin
          wait_cnt = wait_cnt + 32'd1;
        end
        if (wait_cnt < tick_limit) begin
          return 1'b0;
        end
        busy         = 1'b0;
        wait_cnt     = '0;
        r.event_res  = EV_TIMED_OUT;
        r.command_id = next_id - 16'd1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t fresh;
    if (rst) begin
      io_en       = 1'b0;
      cap_sectors = '0;
      max_sec     = 5'd16;
      buf_base    = '0;
      tick_limit  = TIMEOUT_RESET;
      sq_tail     = 0;
      cq_head     = 0;
      phase       = 1'b1;
      next_id     = '0;
      busy        = 1'b0;
      wait_cnt    = '0;
      io_events_q.delete();
    end else begin
      // Results are compared before the new item is predicted, so a result can
      // never be matched against an expectation made at the same edge.
      if (m_tvalid && m_tready) begin
        got.event_res             = m_tuser;
        got.sqe_opcode            = m_tdata[1:0];
        got.command_id            = m_tdata[17:2];
        got.prp_first             = m_tdata[81:18];
        got.prp_second            = m_tdata[145:82];
        got.start_block           = m_tdata[209:146];
        got.block_count_minus_one = m_tdata[225:210];
        got.sq_doorbell_value     = m_tdata[228:226];
        got.cq_doorbell_value     = m_tdata[231:229];
        got.status_field          = m_tdata[246:232];
        if (io_events_q.size() == 0) begin
          flag("result with nothing expected, event", 64'(got.event_res), 64'd0);
        end else begin
          want = io_events_q.pop_front();
          check_field("event_res", 64'(got.event_res), 64'(want.event_res));
          check_field("sqe_opcode", 64'(got.sqe_opcode), 64'(want.sqe_opcode));
          check_field("command_id", 64'(got.command_id), 64'(want.command_id));
          check_field("prp_first", got.prp_first, want.prp_first);
          check_field("prp_second", got.prp_second, want.prp_second);
          check_field("start_block", got.start_block, want.start_block);
          check_field("block_count_minus_one", 64'(got.block_count_minus_one),
                      64'(want.block_count_minus_one));
          check_field("sq_doorbell_value", 64'(got.sq_doorbell_value),
                      64'(want.sq_doorbell_value));
          check_field("cq_doorbell_value", 64'(got.cq_doorbell_value),
                      64'(want.cq_doorbell_value));
          check_field("status_field", 64'(got.status_field), 64'(want.status_field));
        end
      end
      if (s_tvalid && s_tready) begin
        if (next_io_event(op_t'(s_tuser), s_tdata[63:0], s_tdata[79:64], s_tdata[80],
                          s_tdata[96:81], fresh)) begin
          io_events_q.push_back(fresh);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_IO_ENABLED:   io_en       = cfg_data[0];
          REG_CAPACITY:     cap_sectors = cfg_data;
          REG_SECTOR_LIMIT: max_sec     = cfg_data[4:0];
          REG_BOUNCE_BASE:  buf_base    = cfg_data;
          REG_TIMEOUT:      tick_limit  = cfg_data[31:0];
          default: ;
        endcase
      end
    end
    n_open = io_events_q.size();
  end

endmodule

// ===== tb/sv/nvme_io_queue_pair_host_tb.sv =====
// Top of the NVMe I/O queue pair host testbench: clock, reset, configuration phases,
// directed and random stimulus, and the final verdict.
// Depends on nvmq_pkg, the block under test and nvmq_queue_pair_checker.
`timescale 1ns / 1ps

module nvme_io_queue_pair_host_tb;
  import nvmq_pkg::*;

  // An index past the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [2:0]            m_tuser;
  int                    errors;
  int                    outstanding;

  bit          calm = 1'b0;
  int          sent = 0;
  logic [63:0] shape_cap = '0;
  logic [4:0]  shape_max = 5'd16;

  nvme_io_queue_pair_host uut (.*);
  nvmq_queue_pair_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd15_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stalls on m_tready until the last phase.
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      m_tready = calm || $urandom_range(0, 5) != 0;
      if (!m_tready) begin
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Holds the sender until every expected result has come and the pipeline is empty.
  task automatic drain();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(input logic en, input logic [63:0] cap, input logic [4:0] maxs,
                           input logic [63:0] base, input logic [31:0] ticks);
    drain();
    write_reg(REG_IO_ENABLED, 64'(en));
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_SECTOR_LIMIT, 64'(maxs));
    write_reg(REG_BOUNCE_BASE, base);
    write_reg(REG_TIMEOUT, 64'(ticks));
    shape_cap = cap;
    shape_max = maxs;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer with
  // tvalid still high, so the caller either sends again or drains right away.
  task automatic send(input op_t op, input logic [63:0] lba, input logic [15:0] cnt,
                      input logic wr, input logic [15:0] cqe);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {7'd0, cqe, wr, cnt, lba};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (op != OP_UNUSED) begin
      sent++;
    end
  endtask

  task automatic submit_noise();
    send(OP_SUBMIT, rand64(),
         $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 20)),
         1'($urandom), 16'($urandom));
  endtask

  // A submit that fits the current limit and capacity, often right at an edge; with no room, a random submit.
  task automatic submit_fitting();
    logic [63:0] lim;
    logic [63:0] span;
    logic [63:0] lba;
    logic [15:0] cnt;
    lim = (shape_max < 5'd16) ? 64'(shape_max) : 64'd16;
    if (shape_cap < lim) begin
      lim = shape_cap;
    end
    if (lim == 64'd0) begin
      submit_noise();
    end else begin
      cnt  = 16'($urandom_range(1, int'(lim)));
      span = shape_cap - 64'(cnt);
      case ($urandom_range(0, 3))
        0:       lba = 64'd0;
        1:       lba = span;
        default: lba = rand64() % (span + 64'd1);
      endcase
      send(OP_SUBMIT, lba, cnt, 1'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_random(input int n);
    int          goal;
    logic        ph;
    logic [14:0] st;
    goal = sent + n;
    while (sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          // Submit, a few ticks, then mostly completions with both phase tags: whichever
          // tag is stale is ignored and the other retires the command if still in flight.
          submit_fitting();
          repeat ($urandom_range(0, 3)) begin
            send(OP_TICK, rand64(), 16'($urandom), 1'($urandom), 16'($urandom));
          end
          if ($urandom_range(0, 4) != 0) begin
            ph = 1'($urandom);
            st = $urandom_range(0, 1) ? 15'($urandom) : 15'd0;
            send(OP_COMPLETE, rand64(), 16'($urandom), 1'($urandom), {st, ph});
            send(OP_COMPLETE, rand64(), 16'($urandom), 1'($urandom), {15'($urandom), ~ph});
          end
        end
        7: submit_noise();
        8: send(OP_COMPLETE, rand64(), 16'($urandom), 1'($urandom), 16'($urandom));
        default: send(op_t'($urandom_range(0, 3)), rand64(), 16'($urandom), 1'($urandom),
                      16'($urandom));
      endcase
    end
  endtask

  initial begin
    int guard;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Reset configuration: I/O is off, nothing is in flight.
    send(OP_SUBMIT, 64'd0, 16'd1, 1'b1, 16'd0);
    send(OP_COMPLETE, 64'd0, 16'd0, 1'b0, 16'h0001);
    send(OP_TICK, 64'd0, 16'd0, 1'b0, 16'd0);
    send(OP_UNUSED, '1, '1, 1'b1, '1);

    configure(1'b1, 64'd100, 5'd16, 64'h0000_0001_2345_6000, 32'd3);
    send(OP_SUBMIT, 64'd0, 16'd0, 1'b1, 16'd0);
    send(OP_SUBMIT, 64'd0, 16'hFFFF, 1'b0, 16'd0);
    send(OP_SUBMIT, 64'd0, 16'd17, 1'b1, 16'd0);
    send(OP_SUBMIT, 64'd100, 16'd1, 1'b0, 16'd0);
    send(OP_SUBMIT, 64'd99, 16'd2, 1'b1, 16'd0);
    send(OP_SUBMIT, '1, 16'd1, 1'b1, '1);
    // Ends exactly at the capacity and needs the second page pointer.
    send(OP_SUBMIT, 64'd84, 16'd16, 1'b1, 16'd0);
    send(OP_SUBMIT, 64'd0, 16'd1, 1'b0, 16'd0);
    send(OP_COMPLETE, 64'd0, 16'd0, 1'b0, 16'h0000);
    send(OP_COMPLETE, 64'd0, 16'd0, 1'b0, 16'h0001);
    send(OP_COMPLETE, 64'd0, 16'd0, 1'b0, 16'h0001);
    send(OP_SUBMIT, 64'd0, 16'd8, 1'b0, 16'd0);
    send(OP_COMPLETE, '1, '1, 1'b1, 16'hFFFF);
    send(OP_SUBMIT, 64'd50, 16'd9, 1'b0, 16'd0);
    repeat (4) send(OP_TICK, 64'd0, 16'd0, 1'b0, 16'd0);

    configure(1'b1, 64'd64, 5'd16, 64'h0000_0000_0000_1000, 32'd5);
    run_random(280);
    configure(1'b1, '1, 5'd8, 64'hFFFF_FFFF_FFFF_F000, '1);
    run_random(280);
    // The second page pointer wraps past the top of the address space here.
    configure(1'b1, '1, 5'd16, 64'hFFFF_FFFF_FFFF_F000, 32'd1);
    run_random(280);
    configure(1'b0, 64'd1000, 5'd12, 64'd0, 32'd2);
    write_reg(REG_SPARE, '1);
    write_reg(REG_IO_ENABLED, 64'hFFFF_FFFF_FFFF_FFFE);
    run_random(100);
    configure(1'b1, 64'd17, 5'd31, rand64() & ~64'hFFF, 32'd4);
    run_random(280);
    calm = 1'b1;
    configure(1'b1, 64'h0000_0100_0000_0000, 5'd9, rand64() & ~64'hFFF, 32'd7);
    run_random(280);

    s_tvalid = 1'b0;
    for (guard = 0; outstanding != 0 && guard < 5000; guard++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
